[rtl/ckls_pkg.sv]
// Shared types, constants and elaboration-time helpers for the CKLS rate step unit.
// Used by every module under rtl/; depends on nothing else.
package ckls_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int POW_ITERATIONS = 24;

  // counter wide enough for 0..POW_ITERATIONS and for the ten arithmetic slots
  localparam int CNT_W  = $clog2(POW_ITERATIONS + 1);
  localparam int LINT_W = 7;                 // integer part of log2, signed
  localparam int L_W    = LINT_W + 32;       // log2 in Q32
  localparam int LH_W   = L_W - 16;          // upper part of log2
  localparam int E_W    = 28 + LH_W + 1;     // exponent gamma*log2, Q32
  localparam int S_W    = E_W - 32 + 1;      // final shift count
  localparam int P_W    = 31;                // power result, nonnegative
  localparam int PROD_W = 66;

  // configuration register indexes
  localparam logic [2:0] REG_DRIFT   = 3'd0;
  localparam logic [2:0] REG_MREV    = 3'd1;
  localparam logic [2:0] REG_ELAST   = 3'd2;
  localparam logic [2:0] REG_VOL     = 3'd3;
  localparam logic [2:0] REG_INIT    = 3'd4;
  localparam logic [2:0] REG_DT      = 3'd5;
  localparam logic [2:0] REG_SQRT_DT = 3'd6;
  localparam logic [2:0] REG_STEPS   = 3'd7;

  typedef logic signed [PROD_W-1:0] wide_t;

  typedef struct packed {
    logic signed [31:0] normal_sample;
    logic               restart;
  } in_beat_t;

  typedef struct packed {
    logic        [30:0] time_value;
    logic signed [31:0] rate_value;
    logic        [15:0] step_index;
    logic               last_step;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] drift;
    logic signed [31:0] mean_reversion;
    logic        [27:0] elasticity;
    logic signed [31:0] volatility;
    logic signed [31:0] initial_rate;
    logic        [30:0] time_step;
    logic        [30:0] sqrt_time_step;
    logic        [15:0] step_count;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  localparam cfg_t CFG_RESET = '{
    drift:          32'sd1677722,
    mean_reversion: 32'sd3355443,
    elasticity:     28'd8388608,
    volatility:     32'sd335544,
    initial_rate:   32'sd838861,
    time_step:      31'd167772,
    sqrt_time_step: 31'd1677722,
    step_count:     16'd100
  };

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > wide_t'(64'sd2147483647)) return 32'sh7FFF_FFFF;
    if (v < wide_t'(-64'sd2147483648)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // floor square root, bit by bit; elaboration only
  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-n) in Q31 by repeated floor square roots from 2.0
  function automatic logic [31:0] root_factor(int n);
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int i = 1; i <= 32; i++) begin
      if (i <= n) c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

endpackage

[rtl/ckls_mul.sv]
// Shared signed 33x33 multiplier with a registered product.
// Depends on ckls_pkg for the product width.
module ckls_mul (
  input  logic                 clk,
  input  logic signed [32:0]   mul_a,
  input  logic signed [32:0]   mul_b,
  output ckls_pkg::wide_t      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

[rtl/ckls_core.sv]
// Sequencer and datapath for one Euler step: normalize, log2, exp2, then the
// rate update, all through the shared multiplier. Depends on ckls_pkg and ckls_mul.
module ckls_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ckls_pkg::in_beat_t  item,
  input  ckls_pkg::cfg_t      cfg,
  input  logic                take,
  output ckls_pkg::stat_t     stat,
  output ckls_pkg::out_beat_t result
);

  localparam int POW = ckls_pkg::POW_ITERATIONS;
  localparam int FRB = ckls_pkg::FRAC_BITS;
  localparam int CW  = ckls_pkg::CNT_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NORM  = 4'd1;
  localparam logic [3:0] ST_LOG   = 4'd2;
  localparam logic [3:0] ST_EXPO  = 4'd3;
  localparam logic [3:0] ST_EXP   = 4'd4;
  localparam logic [3:0] ST_PWR   = 4'd5;
  localparam logic [3:0] ST_ARITH = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam logic [2:0] OP_MR = 3'd0;  // mean_reversion * r
  localparam logic [2:0] OP_VP = 3'd1;  // volatility * p
  localparam logic [2:0] OP_DT = 3'd2;  // d * dt
  localparam logic [2:0] OP_SQ = 3'd3;  // * sqrt_dt
  localparam logic [2:0] OP_Z  = 3'd4;  // * z

  localparam logic [CW-1:0] NORM_LAST = CW'(4);
  localparam logic [CW-1:0] POW_LAST  = CW'(POW);
  localparam logic signed [ckls_pkg::S_W-1:0] S_FLOOR = -ckls_pkg::S_W'(63);

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [31:0] rate_r, rate_nxt;
  logic [30:0]   time_r, time_nxt;
  logic [15:0]   idx_r, idx_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic [31:0]   u_r, u_nxt;
  logic [4:0]    lz_r, lz_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic signed [ckls_pkg::E_W-1:0] t_r, t_nxt;
  logic [31:0]   fe_r, fe_nxt;
  logic signed [ckls_pkg::S_W-1:0] s_r, s_nxt;
  logic [31:0]   m_r, m_nxt;
  logic [ckls_pkg::P_W-1:0] p_r, p_nxt;
  logic signed [31:0] d_r, d_nxt;
  logic signed [31:0] w_r, w_nxt;
  logic signed [31:0] uu_r, uu_nxt;

  logic signed [32:0] mul_a, mul_b;
  ckls_pkg::wide_t    prod_r;

  logic [31:0] rtab [0:POW];
  for (genvar g = 0; g <= POW; g++) begin : g_rtab
    localparam logic [31:0] RC = ckls_pkg::root_factor(g);
    assign rtab[g] = RC;
  end

  ckls_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  logic [32:0]  sq;
  logic         sq_hi;
  logic [31:0]  u_new;
  logic [31:0]  m_prod;
  logic signed [31:0] rq;
  logic [31:0]  x_abs;
  logic [4:0]   sh;
  logic signed [ckls_pkg::LINT_W-1:0] lint;
  logic signed [ckls_pkg::L_W-1:0]    lval;
  logic signed [ckls_pkg::LH_W-1:0]   lh;
  logic [15:0]  ll;
  logic signed [ckls_pkg::E_W-1:0] esum, e_val;
  logic [CW-1:0] rix;
  logic [2:0]   op;
  logic [31:0]  u_eff, m_eff;
  logic [31:0]  tsum;
  logic signed [33:0] rsum3;

  assign sq     = prod_r[63:31];
  assign sq_hi  = sq[32];
  assign u_new  = sq_hi ? sq[32:1] : sq[31:0];
  assign m_prod = prod_r[62:31];
  assign rq     = ckls_pkg::sat32((prod_r + (ckls_pkg::wide_t'(1) <<< (FRB - 1))) >>> FRB);
  assign x_abs  = rate_r[31] ? (~rate_r + 32'd1) : rate_r;
  assign sh     = 5'd16 >> cnt_r[2:0];
  assign lint   = $signed(ckls_pkg::LINT_W'(31 - FRB)) - $signed(ckls_pkg::LINT_W'(lz_r));
  assign lval   = $signed({lint, acc_r << (32 - POW)});
  assign lh     = ckls_pkg::LH_W'(lval >>> 16);
  assign ll     = lval[15:0];
  assign esum   = t_r + ckls_pkg::E_W'(prod_r >>> 16);
  assign e_val  = esum >>> (FRB - 16);
  assign rix    = (cnt_r == POW_LAST) ? POW_LAST : cnt_r + CW'(1);
  assign op     = cnt_r[3:1];
  assign u_eff  = (cnt_r == '0) ? u_r : u_new;
  assign m_eff  = (cnt_r != '0 && fe_r[31]) ? m_prod : m_r;
  assign tsum   = {1'b0, time_r} + {1'b0, cfg.time_step};
  assign rsum3  = 34'(rate_r) + 34'(uu_r) + 34'(w_r);

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    rate_nxt = rate_r;
    time_nxt = time_r;
    idx_nxt  = idx_r;
    z_nxt    = z_r;
    u_nxt    = u_r;
    lz_nxt   = lz_r;
    acc_nxt  = acc_r;
    t_nxt    = t_r;
    fe_nxt   = fe_r;
    s_nxt    = s_r;
    m_nxt    = m_r;
    p_nxt    = p_r;
    d_nxt    = d_r;
    w_nxt    = w_r;
    uu_nxt   = uu_r;
    mul_a    = '0;
    mul_b    = '0;
    case (st_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          if (item.restart) begin
            rate_nxt = cfg.initial_rate;
            time_nxt = '0;
            idx_nxt  = '0;
            st_nxt   = ST_FIN;
          end else begin
            z_nxt   = item.normal_sample;
            u_nxt   = x_abs;
            lz_nxt  = '0;
            acc_nxt = '0;
            if (cfg.elasticity == '0) begin
              p_nxt  = ckls_pkg::P_W'(1) << FRB;
              st_nxt = ST_ARITH;
            end else if (x_abs == '0) begin
              p_nxt  = '0;
              st_nxt = ST_ARITH;
            end else begin
              st_nxt = ST_NORM;
            end
          end
        end
      end
      ST_NORM: begin
        // binary search for the leading one: 16, 8, 4, 2, 1
        if ((u_r >> (6'd32 - {1'b0, sh})) == '0) begin
          u_nxt  = u_r << sh;
          lz_nxt = lz_r + sh;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == NORM_LAST) begin
          cnt_nxt = '0;
          st_nxt  = ST_LOG;
        end
      end
      ST_LOG: begin
        mul_a = {1'b0, u_eff};
        mul_b = {1'b0, u_eff};
        if (cnt_r != '0) acc_nxt = {acc_r[30:0], sq_hi};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == POW_LAST) begin
          cnt_nxt = '0;
          st_nxt  = ST_EXPO;
        end
      end
      ST_EXPO: begin
        mul_a = {5'b0, cfg.elasticity};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '0) begin
          mul_b = 33'(lh);
        end else if (cnt_r == CW'(1)) begin
          t_nxt = prod_r[ckls_pkg::E_W-1:0];
          mul_b = {17'b0, ll};
        end else begin
          fe_nxt  = e_val[31:0];
          s_nxt   = ckls_pkg::S_W'($signed(e_val[ckls_pkg::E_W-1:32]))
                  + $signed(ckls_pkg::S_W'(FRB - 31));
          m_nxt   = 32'h8000_0000;
          cnt_nxt = '0;
          st_nxt  = ST_EXP;
        end
      end
      ST_EXP: begin
        // take the factor only where the exponent fraction bit is set
        m_nxt = m_eff;
        if (cnt_r != '0) fe_nxt = fe_r << 1;
        mul_a = {1'b0, m_eff};
        mul_b = {1'b0, rtab[rix]};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == POW_LAST) begin
          cnt_nxt = '0;
          st_nxt  = ST_PWR;
        end
      end
      ST_PWR: begin
        if (!s_r[ckls_pkg::S_W-1]) begin
          p_nxt = '1;
        end else if (s_r < S_FLOOR) begin
          p_nxt = '0;
        end else begin
          p_nxt = ckls_pkg::P_W'(m_r >> 6'(-s_r));
        end
        st_nxt = ST_ARITH;
      end
      ST_ARITH: begin
        // even slot: issue; odd slot: round and store
        cnt_nxt = cnt_r + CW'(1);
        if (!cnt_r[0]) begin
          case (op)
            OP_MR: begin
              mul_a = 33'(cfg.mean_reversion);
              mul_b = 33'(rate_r);
            end
            OP_VP: begin
              mul_a = 33'(cfg.volatility);
              mul_b = {2'b0, p_r};
            end
            OP_DT: begin
              mul_a = 33'(d_r);
              mul_b = {2'b0, cfg.time_step};
            end
            OP_SQ: begin
              mul_a = 33'(w_r);
              mul_b = {2'b0, cfg.sqrt_time_step};
            end
            OP_Z: begin
              mul_a = 33'(w_r);
              mul_b = 33'(z_r);
            end
            default: begin
              mul_a = '0;
              mul_b = '0;
            end
          endcase
        end else begin
          case (op)
            OP_MR: d_nxt = ckls_pkg::sat32(ckls_pkg::wide_t'(cfg.drift)
                                           - ckls_pkg::wide_t'(rq));
            OP_VP: w_nxt = rq;
            OP_DT: uu_nxt = rq;
            OP_SQ: w_nxt = rq;
            OP_Z: begin
              w_nxt   = rq;
              cnt_nxt = '0;
              st_nxt  = ST_UPD;
            end
            default: w_nxt = w_r;
          endcase
        end
      end
      ST_UPD: begin
        rate_nxt = ckls_pkg::sat32(ckls_pkg::wide_t'(rsum3));
        time_nxt = tsum[31] ? 31'h7FFF_FFFF : tsum[30:0];
        if (idx_r != 16'hFFFF) idx_nxt = idx_r + 16'd1;
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (take) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cnt_r  <= '0;
      rate_r <= '0;
      time_r <= '0;
      idx_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      rate_r <= rate_nxt;
      time_r <= time_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r  <= z_nxt;
    u_r  <= u_nxt;
    lz_r <= lz_nxt;
    acc_r <= acc_nxt;
    t_r  <= t_nxt;
    fe_r <= fe_nxt;
    s_r  <= s_nxt;
    m_r  <= m_nxt;
    p_r  <= p_nxt;
    d_r  <= d_nxt;
    w_r  <= w_nxt;
    uu_r <= uu_nxt;
  end

  assign stat.busy = (st_r != ST_IDLE);
  assign stat.done = (st_r == ST_FIN);

  assign result.time_value = time_r;
  assign result.rate_value = rate_r;
  assign result.step_index = idx_r;
  assign result.last_step  = (idx_r == cfg.step_count);

endmodule

[rtl/ckls_euler_rate_step_unit.sv]
// Top level of the CKLS short-rate Euler step unit: configuration registers,
// input handshake and output register. Depends on ckls_pkg and ckls_core.
//
//  channel | dir | handshake               | payload
//  in_     | in  | in_valid / in_stall     | ckls_pkg::in_beat_t
//  out_    | out | out_valid / out_stall   | ckls_pkg::out_beat_t
//  cfg_    | in  | cfg_we                  | cfg_index, cfg_wdata
//
// A restart beat only reloads the path state; a step whose power is trivial (zero rate or
// zero elasticity) skips the log2 and exp2 loops; any other step runs the log2 and exp2
// loops through the one shared multiplier.
// Reset is synchronous, active low, and clears the control and path state.
// One finished beat can wait in the output register while the next is worked.
module ckls_euler_rate_step_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ckls_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ckls_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  ckls_pkg::cfg_t      cfg_r, cfg_nxt;
  ckls_pkg::stat_t     stat;
  ckls_pkg::out_beat_t result;
  ckls_pkg::out_beat_t out_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic                take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ckls_pkg::REG_DRIFT:   cfg_nxt.drift          = cfg_wdata;
        ckls_pkg::REG_MREV:    cfg_nxt.mean_reversion = cfg_wdata;
        ckls_pkg::REG_ELAST:   cfg_nxt.elasticity     = cfg_wdata[27:0];
        ckls_pkg::REG_VOL:     cfg_nxt.volatility     = cfg_wdata;
        ckls_pkg::REG_INIT:    cfg_nxt.initial_rate   = cfg_wdata;
        ckls_pkg::REG_DT:      cfg_nxt.time_step      = cfg_wdata[30:0];
        ckls_pkg::REG_SQRT_DT: cfg_nxt.sqrt_time_step = cfg_wdata[30:0];
        ckls_pkg::REG_STEPS:   cfg_nxt.step_count     = cfg_wdata[15:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  assign take = !out_valid_r || !out_stall;

  ckls_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_valid && !in_stall),
    .item   (in_data),
    .cfg    (cfg_r),
    .take   (take),
    .stat   (stat),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.done && take) out_valid_nxt = 1'b1;
    else if (!out_stall)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= ckls_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the beat when the core finishes and the register is free
  always_ff @(posedge clk) begin
    if (stat.done && take) out_data_r <= result;
  end

  assign in_stall  = stat.busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/ckls_checker.sv]
// Port-level checks for the CKLS rate step unit, bound to the top level.
// Depends on ckls_pkg and ckls_euler_rate_step_unit.
module ckls_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ckls_pkg::out_beat_t out_data,
  input logic                out_valid,
  input logic                out_stall
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a beat without going busy");

  a_path_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.step_index == 16'd0) |-> (out_data.time_value == 31'd0))
    else $error("path start reported with nonzero time");

endmodule

bind ckls_euler_rate_step_unit ckls_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

[tb/sv/tb.sv]
// Self-checking testbench for ckls_euler_rate_step_unit: queued driver, monitor,
// and a bit-exact Euler step predictor. Depends on ckls_pkg and the RTL top.
`timescale 1ns / 1ps

module tb;

  localparam longint CYCLE_LIMIT = 500000;
  localparam int     SETTLE      = 100;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ckls_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ckls_pkg::out_beat_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [31:0]         cfg_wdata = '0;

  ckls_euler_rate_step_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ckls_pkg::in_beat_t  sample_q[$];
  ckls_pkg::out_beat_t point_q[$];
  ckls_pkg::cfg_t      regs = ckls_pkg::CFG_RESET;
  longint    path_rate = 0, path_time = 0, path_step = 0;
  int        errors = 0;
  bit        calm = 1'b0;
  bit        squeeze_req = 1'b0;
  bit        squeeze_done = 1'b0;
  longint    cycles = 0;

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (ckls_pkg::FRAC_BITS - 1));
    return sat_s32(p >>> ckls_pkg::FRAC_BITS);
  endfunction

  function automatic bit [63:0] floor_root(bit [63:0] v_in);
    bit [63:0] v, res, bv;
    v = v_in;
    res = 0;
    bv = 64'd1 << 62;
    while (bv != 0) begin
      if (v >= res + bv) begin
        v = v - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // |r|^gamma via truncating log2/exp2 loops
  function automatic longint abs_pow(longint x, longint g);
    int msb;
    bit [63:0] u, m, c;
    longint frac, l, lh, ll, t, bb, e, k, s;
    if (g == 0) return 64'sd1 <<< ckls_pkg::FRAC_BITS;
    if (x == 0) return 0;
    msb = 0;
    for (int i = 0; i < 32; i++) if (x[i]) msb = i;
    u = 64'(x) << (31 - msb);
    frac = 0;
    for (int i = 1; i <= ckls_pkg::POW_ITERATIONS; i++) begin
      u = (u * u) >> 31;
      if (u >= 64'h1_0000_0000) begin
        u = u >> 1;
        frac = frac | (64'sd1 <<< (32 - i));
      end
    end
    l = ((longint'(msb) - ckls_pkg::FRAC_BITS) <<< 32) + frac;
    lh = l >>> 16;
    ll = l - (lh <<< 16);
    t = g * lh;
    bb = g * ll;
    e = (t + (bb >>> 16)) >>> (ckls_pkg::FRAC_BITS - 16);
    k = e >>> 32;
    frac = e - (k <<< 32);
    m = 64'h8000_0000;
    c = 64'h1_0000_0000;
    for (int i = 1; i <= ckls_pkg::POW_ITERATIONS; i++) begin
      c = floor_root(c << 31);
      if (frac[32 - i]) m = (m * c) >> 31;
    end
    s = k + ckls_pkg::FRAC_BITS - 31;
    if (s >= 0) return 64'sd2147483647;
    if (-s > 63) return 0;
    return longint'(m >> (-s));
  endfunction

  function automatic ckls_pkg::out_beat_t next_point(ckls_pkg::in_beat_t b);
    ckls_pkg::out_beat_t o;
    longint r, mag, p, d, u, v;
    if (b.restart) begin
      path_rate = longint'(regs.initial_rate);
      path_time = 0;
      path_step = 0;
    end else begin
      r = path_rate;
      mag = (r < 0) ? -r : r;
      p = abs_pow(mag, longint'(regs.elasticity));
      d = sat_s32(longint'(regs.drift) - qmul(longint'(regs.mean_reversion), r));
      u = qmul(d, longint'(regs.time_step));
      v = qmul(qmul(qmul(longint'(regs.volatility), p), longint'(regs.sqrt_time_step)),
               longint'(b.normal_sample));
      path_rate = sat_s32(r + u + v);
      path_time = path_time + longint'(regs.time_step);
      if (path_time > 64'sd2147483647) path_time = 64'sd2147483647;
      if (path_step < 65535) path_step++;
    end
    o.time_value = path_time[30:0];
    o.rate_value = path_rate[31:0];
    o.step_index = path_step[15:0];
    o.last_step  = (path_step == longint'(regs.step_count));
    return o;
  endfunction

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) point_q.push_back(next_point(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(1, 13) - 1;
        end else if (sample_q.size() > 0) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold_left = 0;
  always @(posedge clk) begin
    ckls_pkg::out_beat_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (point_q.size() == 0) begin
          report("unexpected beat", 64'sd0, 64'sd0);
        end else begin
          w = point_q.pop_front();
          if (out_data.time_value != w.time_value)
            report("time_value", longint'(out_data.time_value), longint'(w.time_value));
          if (out_data.rate_value != w.rate_value)
            report("rate_value", longint'(out_data.rate_value), longint'(w.rate_value));
          if (out_data.step_index != w.step_index)
            report("step_index", longint'(out_data.step_index), longint'(w.step_index));
          if (out_data.last_step != w.last_step)
            report("last_step", longint'(out_data.last_step), longint'(w.last_step));
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (squeeze_req && !squeeze_done) begin
        // long hold so the unit backs up into the input
        out_stall <= 1'b1;
        hold_left <= 400;
        squeeze_done <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        hold_left <= $urandom_range(1, 13) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ckls_euler_rate_step_unit test failed");
      $finish;
    end
  end

  task automatic push(bit rs, logic [31:0] z);
    ckls_pkg::in_beat_t b;
    b.restart = rs;
    b.normal_sample = z;
    sample_q.push_back(b);
  endtask

  function automatic logic [31:0] rand_z();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(longint'($urandom_range(0, 134217728)) - 67108864);
  endfunction

  task automatic drain();
    wait (sample_q.size() == 0 && !in_valid && point_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_all(ckls_pkg::cfg_t nv);
    logic [31:0] vals[8];
    vals[ckls_pkg::REG_DRIFT]   = nv.drift;
    vals[ckls_pkg::REG_MREV]    = nv.mean_reversion;
    vals[ckls_pkg::REG_ELAST]   = 32'(nv.elasticity);
    vals[ckls_pkg::REG_VOL]     = nv.volatility;
    vals[ckls_pkg::REG_INIT]    = nv.initial_rate;
    vals[ckls_pkg::REG_DT]      = 32'(nv.time_step);
    vals[ckls_pkg::REG_SQRT_DT] = 32'(nv.sqrt_time_step);
    vals[ckls_pkg::REG_STEPS]   = 32'(nv.step_count);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = nv;
  endtask

  function automatic logic [31:0] small_s(int span);
    return 32'(longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin
    ckls_pkg::cfg_t nv;
    int   steps;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // steps before any restart, then a short path under reset values
    push(1'b0, 32'h7FFF_FFFF);
    push(1'b0, 32'h8000_0000);
    push(1'b1, 32'h1234_5678);
    push(1'b0, 32'h0);
    push(1'b0, 32'h7FFF_FFFF);
    push(1'b0, 32'h8000_0000);
    push(1'b0, rand_z());
    push(1'b1, 32'hFFFF_FFFF);
    drain();

    nv = '{drift: 32'sh7FFF_FFFF, mean_reversion: 32'sh8000_0000,
           elasticity: 28'd134217728, volatility: 32'sh7FFF_FFFF,
           initial_rate: 32'sh8000_0000, time_step: 31'h7FFF_FFFF,
           sqrt_time_step: 31'h7FFF_FFFF, step_count: 16'd0};
    write_all(nv);
    push(1'b1, 32'h0);
    for (int i = 0; i < 4; i++) push(1'b0, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    push(1'b1, 32'h0);
    drain();

    nv = '{drift: 32'sh8000_0000, mean_reversion: 32'sh7FFF_FFFF,
           elasticity: 28'd0, volatility: 32'sh8000_0000,
           initial_rate: 32'sh7FFF_FFFF, time_step: 31'd0,
           sqrt_time_step: 31'd0, step_count: 16'd65535};
    write_all(nv);
    push(1'b1, 32'h0);
    push(1'b0, 32'h7FFF_FFFF);
    push(1'b0, 32'h8000_0000);
    drain();

    // zero rate with nonzero exponent
    nv = ckls_pkg::CFG_RESET;
    nv.initial_rate = 0;
    nv.elasticity = 28'd1;
    nv.drift = 0;
    nv.step_count = 16'd1;
    write_all(nv);
    push(1'b1, 32'h0);
    push(1'b0, 32'h0100_0000);
    push(1'b0, 32'hFF00_0000);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      nv.drift          = ($urandom_range(0, 3) == 0) ? $urandom : small_s(1 << 25);
      nv.mean_reversion = ($urandom_range(0, 3) == 0) ? $urandom : small_s(1 << 25);
      nv.elasticity     = ($urandom_range(0, 3) == 0) ? 28'($urandom_range(0, 134217728))
                                                      : 28'($urandom_range(0, 1 << 25));
      nv.volatility     = ($urandom_range(0, 3) == 0) ? $urandom : small_s(1 << 24);
      nv.initial_rate   = ($urandom_range(0, 3) == 0) ? $urandom : small_s(1 << 25);
      nv.time_step      = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                      : 31'($urandom_range(0, 1 << 24));
      nv.sqrt_time_step = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                      : 31'($urandom_range(0, 1 << 25));
      nv.step_count     = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 30));
      write_all(nv);
      if (ph == 1) squeeze_req = 1'b1;
      for (int n = 0; n < 50; ) begin
        if ($urandom_range(0, 9) == 0) begin
          push(1'($urandom_range(0, 1)), $urandom);
          n++;
        end else begin
          steps = $urandom_range(0, 30);
          push(1'b1, $urandom);
          for (int s = 0; s < steps; s++) push(1'b0, rand_z());
          n += steps + 1;
        end
      end
      drain();
    end

    // quiet run: cheap steps back to back
    calm = 1'b1;
    nv = ckls_pkg::CFG_RESET;
    nv.elasticity = 28'd0;
    nv.time_step = 31'd1;
    nv.step_count = 16'd65535;
    write_all(nv);
    push(1'b1, 32'h0);
    for (int i = 0; i < 30; i++) push(1'b0, rand_z());
    drain();

    if (errors == 0) begin
      $display("ckls_euler_rate_step_unit test passed");
    end else begin
      $display("ckls_euler_rate_step_unit test failed");
    end
    $finish;
  end

endmodule
